// File: design/jac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jac_pkg
// Shared types and constants of the joystick axis conditioner.
// ----------------------------------------------------------------------------
package jac_pkg;

    localparam int SAMPLE_W = 12;
    localparam int ADC_BITS = 12;
    localparam int ADC_MAX  = (1 << ADC_BITS) - 1;
    localparam int OUT_SPAN = 100;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int DB_W     = 7;
    // largest |sample difference| * OUT_SPAN
    localparam int NUM_W    = $clog2(((1 << SAMPLE_W) - 1) * OUT_SPAN + 1);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] JOB_RUN     = 2'd0;
    localparam logic [1:0] JOB_UNCAL   = 2'd1;
    localparam logic [1:0] JOB_BAD_ADC = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNCAL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [SAMPLE_W-1:0] x_low;
        logic [SAMPLE_W-1:0] x_high;
        logic [SAMPLE_W-1:0] x_mid;
        logic [SAMPLE_W-1:0] y_low;
        logic [SAMPLE_W-1:0] y_high;
        logic [SAMPLE_W-1:0] y_mid;
        logic [DB_W-1:0]     dead_band;
        logic                cal_done;
    } t_cfg;

    typedef struct packed {
        logic                bad;
        logic                zero_half;
        logic                low_half;
        logic                num_neg;
        logic [NUM_W-1:0]    num_mag;
        logic [SAMPLE_W-1:0] den;
    } t_axis_job;

    typedef struct packed {
        logic [1:0] kind;
        t_axis_job  x;
        t_axis_job  y;
    } t_job;

endpackage

// File: design/joystick_axis_conditioner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_axis_conditioner
// Maps raw X/Y joystick ADC samples to smoothed, dead-zoned -100..+100 values.
// ----------------------------------------------------------------------------
// Each input beat carries one X and one Y sample and yields one output beat.
// For a calibrated item the piecewise-linear mapping runs through a radix-2
// divider per axis, one quotient bit per cycle over 19 bits, followed by the
// ring average (a reciprocal multiply) and the dead zone. Items arriving while
// the block is not calibrated skip these steps. A two-entry job queue sits
// between the input stage and the arithmetic, and the output beat is held in
// a register, so the input keeps accepting while a result waits, until the
// queue fills. Configuration writes (index 0..7: x_low, x_high, x_mid, y_low,
// y_high, y_mid, dead_band, cal_done) belong in idle periods; each one
// restarts the smoothing so the next item fills the averaging ring. There is
// no clearing pass after reset.
// ----------------------------------------------------------------------------
module joystick_axis_conditioner #(
    parameter int AVG_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [11:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // x_sample[11:0], y_sample[23:12]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // x_pos[7:0], y_pos[15:8], status[17:16], zero
);

    localparam logic [2:0] REG_X_LOW     = 3'd0;
    localparam logic [2:0] REG_X_HIGH    = 3'd1;
    localparam logic [2:0] REG_X_MID     = 3'd2;
    localparam logic [2:0] REG_Y_LOW     = 3'd3;
    localparam logic [2:0] REG_Y_HIGH    = 3'd4;
    localparam logic [2:0] REG_Y_MID     = 3'd5;
    localparam logic [2:0] REG_DEAD_BAND = 3'd6;
    localparam logic [2:0] REG_CAL_DONE  = 3'd7;

    localparam int POS_W = jac_pkg::POS_W;
    localparam logic signed [POS_W-1:0] POS_LIM = POS_W'(jac_pkg::OUT_SPAN);

    jac_pkg::t_cfg r_cfg;
    jac_pkg::t_job front_job;
    jac_pkg::t_job back_job;
    logic          front_valid, front_ready;
    logic          back_valid, back_ready;
    logic signed [POS_W-1:0]      x_pos, y_pos;
    logic [jac_pkg::STATUS_W-1:0] status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_low     <= 12'd0;
            r_cfg.x_high    <= 12'd4095;
            r_cfg.x_mid     <= 12'd2048;
            r_cfg.y_low     <= 12'd0;
            r_cfg.y_high    <= 12'd4095;
            r_cfg.y_mid     <= 12'd2048;
            r_cfg.dead_band <= 7'd5;
            r_cfg.cal_done  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_X_LOW:     r_cfg.x_low     <= i_cfg_wdata;
                REG_X_HIGH:    r_cfg.x_high    <= i_cfg_wdata;
                REG_X_MID:     r_cfg.x_mid     <= i_cfg_wdata;
                REG_Y_LOW:     r_cfg.y_low     <= i_cfg_wdata;
                REG_Y_HIGH:    r_cfg.y_high    <= i_cfg_wdata;
                REG_Y_MID:     r_cfg.y_mid     <= i_cfg_wdata;
                REG_DEAD_BAND: r_cfg.dead_band <= i_cfg_wdata[jac_pkg::DB_W-1:0];
                REG_CAL_DONE:  r_cfg.cal_done  <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    jac_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_x_sample  (s_axis_tdata[11:0]),
        .i_y_sample  (s_axis_tdata[23:12]),
        .o_job_valid (front_valid),
        .i_job_ready (front_ready),
        .o_job       (front_job)
    );

    jac_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_data  (front_job),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready),
        .o_pop_data   (back_job)
    );

    jac_back #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dead_band (r_cfg.dead_band),
        .i_cfg_we    (i_cfg_we),
        .i_job_valid (back_valid),
        .o_job_ready (back_ready),
        .i_job       (back_job),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_x_pos     (x_pos),
        .o_y_pos     (y_pos),
        .o_status    (status)
    );

    assign m_axis_tdata = {6'd0, status, y_pos, x_pos};

    a_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (x_pos <= POS_LIM && x_pos >= -POS_LIM))
        else $error("x_pos beyond span");

    a_y_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (y_pos <= POS_LIM && y_pos >= -POS_LIM))
        else $error("y_pos beyond span");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (status == jac_pkg::ST_OK || status == jac_pkg::ST_UNCAL
                           || status == jac_pkg::ST_RANGE))
        else $error("illegal status code");

    a_uncal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && status == jac_pkg::ST_UNCAL) |-> (x_pos == '0 && y_pos == '0))
        else $error("uncalibrated beat with nonzero position");

endmodule

// File: design/jac_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jac_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module jac_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/jac_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jac_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module jac_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [jac_pkg::NUM_W-1:0]    i_dividend,
    input  logic [jac_pkg::SAMPLE_W-1:0] i_divisor,
    output logic                         o_busy,
    output logic [jac_pkg::NUM_W-1:0]    o_quotient
);

    localparam int NUM_W = jac_pkg::NUM_W;
    localparam int DEN_W = jac_pkg::SAMPLE_W;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] r_rem, n_rem;
    logic [NUM_W-1:0] r_quo, n_quo;
    logic [DEN_W-1:0] r_den, n_den;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   trial;

    always_comb begin
        shifted = {r_rem, r_quo[NUM_W-1]};
        trial   = shifted - {1'b0, r_den};
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_den   = r_den;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_dividend;
            n_den  = i_divisor;
            n_cnt  = CNT_W'(NUM_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (shifted >= {1'b0, r_den}) begin
                n_rem = trial[DEN_W-1:0];
                n_quo = {r_quo[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = shifted[DEN_W-1:0];
                n_quo = {r_quo[NUM_W-2:0], 1'b0};
            end
            n_cnt  = r_cnt - 1'b1;
            n_busy = (r_cnt != CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

// File: design/jac_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jac_queue
// Short job queue between the classifying front end and the back end.
// ----------------------------------------------------------------------------
module jac_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  jac_pkg::t_job i_push_data,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output jac_pkg::t_job o_pop_data
);

    localparam int QD     = jac_pkg::QUEUE_DEPTH;
    localparam int QPTR_W = (QD > 1) ? $clog2(QD) : 1;
    localparam int QCNT_W = $clog2(QD + 1);

    jac_pkg::t_job     r_mem [QD];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != QCNT_W'(QD));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (push) begin
            n_wr = (r_wr == QPTR_W'(QD - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop) begin
            n_rd = (r_rd == QPTR_W'(QD - 1)) ? '0 : r_rd + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

// File: design/jac_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jac_front
// Takes sample beats, classifies them and prepares the mapping division.
// ----------------------------------------------------------------------------
module jac_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  jac_pkg::t_cfg                i_cfg,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [jac_pkg::SAMPLE_W-1:0] i_x_sample,
    input  logic [jac_pkg::SAMPLE_W-1:0] i_y_sample,
    output logic                         o_job_valid,
    input  logic                         i_job_ready,
    output jac_pkg::t_job                o_job
);

    localparam int NUM_W = jac_pkg::NUM_W;
    localparam int SW    = jac_pkg::SAMPLE_W;
    localparam logic [NUM_W-1:0] SPAN_N = NUM_W'(jac_pkg::OUT_SPAN);

    function automatic jac_pkg::t_axis_job prep_axis(
        input logic [SW-1:0] raw,
        input logic [SW-1:0] lo,
        input logic [SW-1:0] hi,
        input logic [SW-1:0] mid
    );
        jac_pkg::t_axis_job j;
        logic [SW-1:0]      mid_c;
        logic [SW-1:0]      mag;
        j     = '0;
        j.bad = (hi <= lo);
        if (mid < lo) begin
            mid_c = lo;
        end else if (mid > hi) begin
            mid_c = hi;
        end else begin
            mid_c = mid;
        end
        if (raw >= mid_c) begin
            j.low_half  = 1'b0;
            j.zero_half = (hi == mid_c);
            j.num_neg   = 1'b0;
            mag         = raw - mid_c;
            j.den       = hi - mid_c;
        end else begin
            j.low_half  = 1'b1;
            j.zero_half = (lo == mid_c);
            j.num_neg   = (raw < lo);
            mag         = (raw < lo) ? (lo - raw) : (raw - lo);
            j.den       = mid_c - lo;
        end
        j.num_mag = NUM_W'(mag) * SPAN_N;
        return j;
    endfunction

    jac_pkg::t_job r_job, n_job;
    logic          r_valid;
    logic          accept;

    assign o_ready     = !r_valid || i_job_ready;
    assign accept      = i_valid && o_ready;
    assign o_job_valid = r_valid;
    assign o_job       = r_job;

    always_comb begin
        n_job   = '0;
        n_job.x = prep_axis(i_x_sample, i_cfg.x_low, i_cfg.x_high, i_cfg.x_mid);
        n_job.y = prep_axis(i_y_sample, i_cfg.y_low, i_cfg.y_high, i_cfg.y_mid);
        if (!i_cfg.cal_done) begin
            n_job.kind = jac_pkg::JOB_UNCAL;
        end else if (int'(i_x_sample) > jac_pkg::ADC_MAX
                     || int'(i_y_sample) > jac_pkg::ADC_MAX) begin
            n_job.kind = jac_pkg::JOB_BAD_ADC;
        end else begin
            n_job.kind = jac_pkg::JOB_RUN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_job_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= n_job;
        end
    end

endmodule

// File: design/jac_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jac_back
// Runs the mapping division, ring average and dead zone for one job.
// ----------------------------------------------------------------------------
module jac_back #(
    parameter int AVG_DEPTH = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [jac_pkg::DB_W-1:0]            i_dead_band,
    input  logic                                i_cfg_we,
    input  logic                                i_job_valid,
    output logic                                o_job_ready,
    input  jac_pkg::t_job                       i_job,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [jac_pkg::POS_W-1:0]    o_x_pos,
    output logic signed [jac_pkg::POS_W-1:0]    o_y_pos,
    output logic [jac_pkg::STATUS_W-1:0]        o_status
);

    localparam int NUM_W    = jac_pkg::NUM_W;
    localparam int POS_W    = jac_pkg::POS_W;
    localparam int OUT_SPAN = jac_pkg::OUT_SPAN;
    localparam int PTR_W    = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int CNT_W    = $clog2(AVG_DEPTH + 1);
    localparam int SUM_MAX  = OUT_SPAN * AVG_DEPTH;
    localparam int MAG_W    = $clog2(SUM_MAX + 1);
    localparam int SUM_W    = MAG_W + 1;
    localparam int SHIFT    = MAG_W + $clog2(AVG_DEPTH);
    localparam int RECIP    = ((1 << SHIFT) + AVG_DEPTH - 1) / AVG_DEPTH;
    localparam int RECIP_W  = SHIFT + 1;
    localparam int PROD_W   = MAG_W + RECIP_W;
    localparam int AVG_W    = $clog2(OUT_SPAN + 1);

    localparam logic signed [POS_W:0]   SPAN_S  = (POS_W + 1)'(OUT_SPAN);
    localparam logic signed [SUM_W-1:0] DEPTH_S = SUM_W'(AVG_DEPTH);
    localparam logic [PROD_W-1:0]       RECIP_V = PROD_W'(RECIP);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_SUM  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    function automatic logic signed [POS_W-1:0] map_axis(
        input jac_pkg::t_axis_job j,
        input logic [NUM_W-1:0]   q
    );
        logic signed [POS_W:0] t;
        t = '0;
        if (j.bad || j.zero_half) begin
            t = '0;
        end else if (j.low_half) begin
            if (j.num_neg) begin
                t = -SPAN_S;
            end else if (q >= NUM_W'(2 * OUT_SPAN)) begin
                t = SPAN_S;
            end else begin
                t = $signed({1'b0, q[POS_W-1:0]}) - SPAN_S;
            end
        end else if (q >= NUM_W'(OUT_SPAN)) begin
            t = SPAN_S;
        end else begin
            t = $signed({1'b0, q[POS_W-1:0]});
        end
        return t[POS_W-1:0];
    endfunction

    function automatic logic signed [POS_W-1:0] dead_zone(
        input logic [AVG_W-1:0]         q,
        input logic                     neg,
        input logic [jac_pkg::DB_W-1:0] band
    );
        logic signed [POS_W-1:0] v;
        v = $signed(POS_W'(q));
        if (q < band) begin
            v = '0;
        end else if (neg) begin
            v = -v;
        end
        return v;
    endfunction

    logic [2:0]                 r_state, n_state;
    jac_pkg::t_job              r_job;
    logic signed [POS_W-1:0]    r_vx, r_vy;
    logic signed [SUM_W-1:0]    r_sum_x, r_sum_y, n_sum_x, n_sum_y;
    logic signed [POS_W-1:0]    r_prime_x, r_prime_y;
    logic [CNT_W-1:0]           r_fill, n_fill;
    logic [PTR_W-1:0]           r_pos;
    logic                       r_primed;
    logic [PROD_W-1:0]          r_prod_x, r_prod_y;
    logic                       r_neg_x, r_neg_y;
    logic                       r_out_valid;
    logic signed [POS_W-1:0]    r_x_pos, r_y_pos;
    logic [jac_pkg::STATUS_W-1:0] r_status;

    logic                       pop;
    logic                       div_start;
    logic                       busy_x, busy_y;
    logic [NUM_W-1:0]           quo_x, quo_y;
    logic [2*POS_W-1:0]         ram_rdata;
    logic                       ram_we;
    logic signed [POS_W-1:0]    old_x, old_y;
    logic signed [SUM_W-1:0]    ext_vx, ext_vy, ext_old_x, ext_old_y;
    logic [SUM_W-1:0]           abs_x, abs_y;
    logic [MAG_W-1:0]           mag_x, mag_y;
    logic [AVG_W-1:0]           avg_x, avg_y;
    logic                       out_free;
    logic                       load_out;
    logic signed [POS_W-1:0]    res_x, res_y;
    logic [jac_pkg::STATUS_W-1:0] res_status;

    assign o_job_ready = (r_state == S_IDLE);
    assign pop         = i_job_valid && o_job_ready;
    assign div_start   = pop && (i_job.kind == jac_pkg::JOB_RUN);
    assign ram_we      = (r_state == S_SUM);
    assign out_free    = !r_out_valid || i_ready;
    assign load_out    = (r_state == S_FIN) && out_free;

    jac_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_job.x.num_mag),
        .i_divisor  (i_job.x.den),
        .o_busy     (busy_x),
        .o_quotient (quo_x)
    );

    jac_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_job.y.num_mag),
        .i_divisor  (i_job.y.den),
        .o_busy     (busy_y),
        .o_quotient (quo_y)
    );

    jac_ram #(
        .WIDTH (2 * POS_W),
        .DEPTH (AVG_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pos),
        .i_wdata ({r_vy, r_vx}),
        .i_re    (div_start),
        .i_raddr (r_pos),
        .o_rdata (ram_rdata)
    );

    // ring entries not rewritten since priming are read as the prime value
    always_comb begin
        old_x     = (r_fill < CNT_W'(AVG_DEPTH)) ? r_prime_x : $signed(ram_rdata[POS_W-1:0]);
        old_y     = (r_fill < CNT_W'(AVG_DEPTH)) ? r_prime_y
                                                 : $signed(ram_rdata[2*POS_W-1:POS_W]);
        ext_vx    = SUM_W'(r_vx);
        ext_vy    = SUM_W'(r_vy);
        ext_old_x = SUM_W'(old_x);
        ext_old_y = SUM_W'(old_y);
        if (!r_primed) begin
            n_sum_x = ext_vx * DEPTH_S;
            n_sum_y = ext_vy * DEPTH_S;
            n_fill  = CNT_W'(1);
        end else begin
            n_sum_x = r_sum_x - ext_old_x + ext_vx;
            n_sum_y = r_sum_y - ext_old_y + ext_vy;
            n_fill  = (r_fill == CNT_W'(AVG_DEPTH)) ? r_fill : r_fill + 1'b1;
        end
    end

    always_comb begin
        abs_x = r_sum_x[SUM_W-1] ? SUM_W'(-r_sum_x) : SUM_W'(r_sum_x);
        abs_y = r_sum_y[SUM_W-1] ? SUM_W'(-r_sum_y) : SUM_W'(r_sum_y);
        mag_x = abs_x[MAG_W-1:0];
        mag_y = abs_y[MAG_W-1:0];
        avg_x = r_prod_x[SHIFT +: AVG_W];
        avg_y = r_prod_y[SHIFT +: AVG_W];
    end

    always_comb begin
        case (r_job.kind)
            jac_pkg::JOB_RUN: begin
                res_x      = dead_zone(avg_x, r_neg_x, i_dead_band);
                res_y      = dead_zone(avg_y, r_neg_y, i_dead_band);
                res_status = (r_job.x.bad || r_job.y.bad) ? jac_pkg::ST_RANGE
                                                          : jac_pkg::ST_OK;
            end
            jac_pkg::JOB_UNCAL: begin
                res_x      = '0;
                res_y      = '0;
                res_status = jac_pkg::ST_UNCAL;
            end
            default: begin
                res_x      = '0;
                res_y      = '0;
                res_status = jac_pkg::ST_RANGE;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (pop) begin
                    n_state = (i_job.kind == jac_pkg::JOB_RUN) ? S_DIV : S_FIN;
                end
            end
            S_DIV: begin
                if (!busy_x && !busy_y) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_pos       <= '0;
            r_primed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_SUM) begin
                r_fill   <= n_fill;
                r_pos    <= (r_pos == PTR_W'(AVG_DEPTH - 1)) ? '0 : r_pos + 1'b1;
                r_primed <= 1'b1;
            end
            if (i_cfg_we) begin
                r_primed <= 1'b0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_job <= i_job;
        end
        if (r_state == S_DIV && !busy_x && !busy_y) begin
            r_vx <= map_axis(r_job.x, quo_x);
            r_vy <= map_axis(r_job.y, quo_y);
        end
        if (r_state == S_SUM) begin
            r_sum_x <= n_sum_x;
            r_sum_y <= n_sum_y;
            if (!r_primed) begin
                r_prime_x <= r_vx;
                r_prime_y <= r_vy;
            end
        end
        if (r_state == S_MUL) begin
            r_prod_x <= PROD_W'(mag_x) * RECIP_V;
            r_prod_y <= PROD_W'(mag_y) * RECIP_V;
            r_neg_x  <= r_sum_x[SUM_W-1];
            r_neg_y  <= r_sum_y[SUM_W-1];
        end
        if (load_out) begin
            r_x_pos  <= res_x;
            r_y_pos  <= res_y;
            r_status <= res_status;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_x_pos  = r_x_pos;
    assign o_y_pos  = r_y_pos;
    assign o_status = r_status;

endmodule
